// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/tuopl_pkg.sv =====
// ----------------------------------------------------------------------------
// tuopl_pkg
// Constants for the tunable one-pole low-pass unit: defaults, fixed-point
// formats and the series divisors used to build the coefficient table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tuopl_pkg;

  localparam int SAMPLE_RATE_DEF  = 48000;
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int CODE_W     = 10;
  localparam int ALPHA_W    = 18;
  localparam int ALPHA_FRAC = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(131072);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] FC_MIN  = 64'd20;
  localparam logic [63:0] R_BASE  = 64'd40;
  localparam logic [63:0] FS_CAP  = 64'd88200;

  localparam logic [63:0] EXP_DIV [20] = '{
    64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
    64'd11, 64'd12, 64'd13, 64'd14, 64'd15, 64'd16, 64'd17, 64'd18, 64'd19, 64'd20
  };

  localparam logic [63:0] SIN_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam logic [63:0] COS_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

endpackage

// ===== hdl/tuopl_ram.sv =====
// ----------------------------------------------------------------------------
// tuopl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuopl_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/tunable_one_pole_low_pass_unit.sv =====
// Path: RAM read register and stage 1 (v1_r, x1_r), then the output register.
// Throughput: one beat per cycle unless out_stall or the RAM fill holds the
// input; the coefficient RAM read and one multiply set the per-beat work,
// split across the RAM read register and the result. Reset: previous input
// and output clear to zero; the coefficient RAM then fills, with in_stall high.
// ----------------------------------------------------------------------------
// tunable_one_pole_low_pass_unit
// First-order bilinear low-pass filter with a per-sample cutoff knob that
// selects an exponentially spaced coefficient from a RAM loaded after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tunable_one_pole_low_pass_unit #(
  parameter int SAMPLE_RATE  = tuopl_pkg::SAMPLE_RATE_DEF,
  parameter int TABLE_DEPTH  = tuopl_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = tuopl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_sample_in,
  input  logic        [tuopl_pkg::CODE_W-1:0]   in_cutoff_code,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int ALPHA_W = tuopl_pkg::ALPHA_W;
  localparam int PW      = SW + ALPHA_W + 3;
  localparam int DW      = SW + 3;

  localparam logic [63:0] FS_EFF    = (SAMPLE_RATE < 40) ? 64'd40 : 64'(SAMPLE_RATE);
  localparam logic [63:0] FS_RATIO  = (FS_EFF > tuopl_pkg::FS_CAP) ? tuopl_pkg::FS_CAP : FS_EFF;
  localparam logic [63:0] STEP_DEN  = (TABLE_DEPTH >= 2) ? 64'(TABLE_DEPTH - 1) : 64'd1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  localparam logic signed [DW-1:0] Y_MAX = DW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] Y_MIN = -Y_MAX - DW'(1);
  localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd1 <<< (tuopl_pkg::ALPHA_FRAC - 1));

  typedef logic [ALPHA_W-1:0] alpha_tab_t [TABLE_DEPTH];

  function automatic alpha_tab_t build_alpha_tab();
    alpha_tab_t         tab;
    logic [63:0]        ip, x, frac, lg, e, tt, term, sum, q, norm, theta, t2;
    logic [63:0]        sterm, cterm, quo;
    logic signed [63:0] s, c, den, num, dsh;
    ip = 64'd0;
    frac = 64'd0;
    for (int j = 0; j < 40; j++) begin
      if ((tuopl_pkg::R_BASE << (j + 1)) <= FS_RATIO) begin
        ip = 64'(j + 1);
      end
    end
    x = ((FS_RATIO << 30) / 64'd40) >> ip;
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 30;
      if (x >= (tuopl_pkg::Q30_ONE << 1)) begin
        frac[31 - i] = 1'b1;
        x = x >> 1;
      end
    end
    lg = (ip << 32) | frac;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      e = (TABLE_DEPTH >= 2) ? (lg * 64'(k)) / STEP_DEN : 64'd0;
      tt = (({32'd0, e[31:0]} >> 2) * tuopl_pkg::LN2_Q30) >> 30;
      term = tuopl_pkg::Q30_ONE;
      sum = tuopl_pkg::Q30_ONE;
      for (int n = 0; n < 20; n++) begin
        term = ((term * tt) >> 30) / tuopl_pkg::EXP_DIV[n];
        sum = sum + term;
      end
      q = sum << e[36:32];
      norm = (q * tuopl_pkg::FC_MIN) / FS_EFF;
      if (norm >= (tuopl_pkg::Q30_ONE >> 1)) begin
        tab[k] = tuopl_pkg::ALPHA_ONE;
      end else begin
        theta = (norm * tuopl_pkg::PI_Q30) >> 30;
        t2 = (theta * theta) >> 30;
        sterm = theta;
        cterm = tuopl_pkg::Q30_ONE;
        s = $signed(theta);
        c = $signed(tuopl_pkg::Q30_ONE);
        for (int i = 0; i < 12; i++) begin
          sterm = ((sterm * t2) >> 30) / tuopl_pkg::SIN_DIV[i];
          cterm = ((cterm * t2) >> 30) / tuopl_pkg::COS_DIV[i];
          if (i % 2 == 0) begin
            s = s - $signed(sterm);
            c = c - $signed(cterm);
          end else begin
            s = s + $signed(sterm);
            c = c + $signed(cterm);
          end
        end
        if (c < 0) c = 64'sd0;
        if (s < 0) s = 64'sd0;
        den = s + c;
        if (den <= 0) begin
          tab[k] = '0;
        end else begin
          num = (s <<< 17) + (den >>> 1);
          quo = 64'd0;
          for (int b = 19; b >= 0; b--) begin
            dsh = den <<< b;
            if (num >= dsh) begin
              num = num - dsh;
              quo[b] = 1'b1;
            end
          end
          if (quo > 64'(tuopl_pkg::ALPHA_ONE)) begin
            quo = 64'(tuopl_pkg::ALPHA_ONE);
          end
          tab[k] = ALPHA_W'(quo);
        end
      end
    end
    return tab;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha_tab();

  logic                 fill_r;
  logic [AW-1:0]        fill_cnt_r;
  logic                 v1_r;
  logic signed [SW-1:0] x1_r;
  logic signed [SW-1:0] x_prev_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_sample_r;

  logic                 accept_in;
  logic                 adv2;
  logic [AW-1:0]        rd_addr;
  logic [ALPHA_W-1:0]   alpha;
  logic signed [SW+1:0] acc;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] delta;
  logic signed [DW-1:0] y_wide;
  logic signed [SW-1:0] y_sat;

  assign adv2      = v1_r && (!out_valid_r || !out_stall);
  assign in_stall  = fill_r || (v1_r && !adv2);
  assign accept_in = in_valid && !in_stall;
  assign rd_addr   = (32'(in_cutoff_code) >= 32'(TABLE_DEPTH)) ? LAST_ADDR
                                                              : AW'(in_cutoff_code);

  tuopl_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (fill_r),
    .wr_addr (fill_cnt_r),
    .wr_data (ALPHA_TAB[fill_cnt_r]),
    .rd_en   (accept_in),
    .rd_addr (rd_addr),
    .rd_data (alpha)
  );

  always_comb begin
    acc    = (SW+2)'(x1_r) + (SW+2)'(x_prev_r) - ((SW+2)'(out_sample_r) <<< 1);
    prod   = PW'(acc) * PW'($signed({1'b0, alpha}));
    delta  = (prod + RND_HALF) >>> tuopl_pkg::ALPHA_FRAC;
    y_wide = DW'(out_sample_r) + DW'(delta);
    if (y_wide > Y_MAX) begin
      y_sat = SW'(Y_MAX);
    end else if (y_wide < Y_MIN) begin
      y_sat = SW'(Y_MIN);
    end else begin
      y_sat = SW'(y_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= 1'b1;
      fill_cnt_r   <= '0;
      v1_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      x_prev_r     <= '0;
      out_sample_r <= '0;
    end else begin
      if (fill_r) begin
        fill_cnt_r <= fill_cnt_r + AW'(1);
        if (fill_cnt_r == LAST_ADDR) begin
          fill_r <= 1'b0;
        end
      end
      if (accept_in) begin
        v1_r <= 1'b1;
        x1_r <= in_sample_in;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= y_sat;
        x_prev_r     <= x1_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  `ASSERT_IMPLIES(a_fill_pipe_empty, clk, rst_n, fill_r, (!v1_r && !out_valid_r))
  `ASSERT_NEXT(a_accept_loads_stage, clk, rst_n, accept_in, v1_r)
  `ASSERT_NEXT(a_advance_shows_beat, clk, rst_n, adv2, out_valid_r)

endmodule
